### hdl/far_pkg.sv
`default_nettype none

package far_pkg;

	localparam int unsigned InW   = 32;
	localparam int unsigned WideW = 64;
	localparam int unsigned DenW  = 62;
	localparam int unsigned CntW  = 7;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL0,
		ST_MUL1,
		ST_MUL2,
		ST_MUL3,
		ST_SUM,
		ST_TZ,
		ST_GCD,
		ST_DIVN_GO,
		ST_DIVN_WAIT,
		ST_DIVD_GO,
		ST_DIVD_WAIT,
		ST_FIN
	} far_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	function automatic logic [InW-1:0] mag32(input logic [InW-1:0] x);
		return x[InW-1] ? (~x + InW'(1)) : x;
	endfunction

endpackage

`default_nettype wire

### hdl/far_mul.sv
`default_nettype none

module far_mul (
	input  wire logic                          clk,
	input  wire logic [far_pkg::InW-1:0]       a,
	input  wire logic [far_pkg::InW-1:0]       b,
	output logic      [far_pkg::WideW-1:0]     prod
);

	logic [far_pkg::WideW-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= far_pkg::WideW'(a) * far_pkg::WideW'(b);
	end

	assign prod = prod_q;

endmodule

`default_nettype wire

### hdl/far_div.sv
`default_nettype none

module far_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [far_pkg::WideW-1:0]     dividend,
	input  wire logic [far_pkg::WideW-1:0]     divisor,
	output logic      [far_pkg::WideW-1:0]     quotient,
	output far_pkg::div_stat_t                 stat
);

	logic [far_pkg::WideW-1:0] quo_q;
	logic [far_pkg::WideW-1:0] rem_q;
	logic [far_pkg::WideW-1:0] dsr_q;
	logic [far_pkg::CntW-1:0]  cnt_q;
	logic                      busy_q;
	logic                      done_q;
	logic [far_pkg::WideW:0]   shifted;
	logic [far_pkg::WideW:0]   diff;
	logic                      fits;

	// restoring divider, one quotient bit a cycle
	assign shifted = {rem_q, quo_q[far_pkg::WideW-1]};
	assign diff    = shifted - {1'b0, dsr_q};
	assign fits    = !diff[far_pkg::WideW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + far_pkg::CntW'(1);
				if (cnt_q == far_pkg::CntW'(far_pkg::WideW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[far_pkg::WideW-2:0], fits};
			rem_q <= fits ? diff[far_pkg::WideW-1:0] : shifted[far_pkg::WideW-1:0];
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

`default_nettype wire

### hdl/fraction_add_reduce_core.sv
// Adds two signed 32-bit fractions and returns the sum in lowest terms with a
// positive denominator; a zero input denominator gives 0/1 with bad_input set,
// a zero sum gives 0/1. One item is handled at a time: in_ready is high only
// while the sequencer is idle. The three products of an item are formed in turn
// on a single 32x32 multiplier, then a binary gcd runs (one shift or one
// 64-bit subtract a cycle), then two divisions by the gcd share one restoring
// divider; a bad input goes from idle straight to the finish state. The result
// sits in an output register, so the next item is taken while a finished
// result still waits.
`default_nettype none

module fraction_add_reduce_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic signed [far_pkg::InW-1:0] num_a,
	input  wire logic signed [far_pkg::InW-1:0] den_a,
	input  wire logic signed [far_pkg::InW-1:0] num_b,
	input  wire logic signed [far_pkg::InW-1:0] den_b,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic signed [far_pkg::WideW-1:0]   sum_num,
	output logic        [far_pkg::DenW-1:0]    sum_den,
	output logic                               bad_input
);

	far_pkg::far_state_t state_q, state_d;

	logic [far_pkg::InW-1:0]   mna_q, mda_q, mnb_q, mdb_q;
	logic                      sa_q, sb_q, neg_q, bad_q;
	logic [far_pkg::WideW-1:0] p1_q, p2_q;
	logic [far_pkg::WideW-1:0] mag_q, den_q;
	logic [far_pkg::WideW-1:0] a_q, b_q, g_q;
	logic [5:0]                k_q;

	logic [far_pkg::InW-1:0]   mul_a, mul_b;
	logic [far_pkg::WideW-1:0] prod;
	logic                      div_start;
	logic [far_pkg::WideW-1:0] div_dividend;
	logic [far_pkg::WideW-1:0] quotient;
	far_pkg::div_stat_t        div_stat;

	logic                      out_valid_q;
	logic [far_pkg::WideW-1:0] sum_num_q;
	logic [far_pkg::DenW-1:0]  sum_den_q;
	logic                      bad_input_q;

	logic                      accept;
	logic                      out_free;
	logic                      in_bad;
	logic [far_pkg::WideW-1:0] sum_mag;
	logic                      sum_neg;
	logic                      a_ge_b;

	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign in_bad   = (den_a == '0) || (den_b == '0);
	assign a_ge_b   = a_q >= b_q;

	always_comb begin
		if (sa_q == sb_q) begin
			sum_mag = p1_q + p2_q;
			sum_neg = sa_q;
		end else if (p1_q >= p2_q) begin
			sum_mag = p1_q - p2_q;
			sum_neg = sa_q;
		end else begin
			sum_mag = p2_q - p1_q;
			sum_neg = sb_q;
		end
	end

	far_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	far_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (g_q),
		.quotient (quotient),
		.stat     (div_stat)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			far_pkg::ST_IDLE:      if (in_valid) state_d = in_bad ? far_pkg::ST_FIN : far_pkg::ST_MUL0;
			far_pkg::ST_MUL0:      state_d = far_pkg::ST_MUL1;
			far_pkg::ST_MUL1:      state_d = far_pkg::ST_MUL2;
			far_pkg::ST_MUL2:      state_d = far_pkg::ST_MUL3;
			far_pkg::ST_MUL3:      state_d = far_pkg::ST_SUM;
			far_pkg::ST_SUM:       state_d = (sum_mag == '0) ? far_pkg::ST_FIN : far_pkg::ST_TZ;
			far_pkg::ST_TZ:        if (a_q[0] || b_q[0]) state_d = far_pkg::ST_GCD;
			far_pkg::ST_GCD:       if (a_q == '0) state_d = far_pkg::ST_DIVN_GO;
			far_pkg::ST_DIVN_GO:   state_d = far_pkg::ST_DIVN_WAIT;
			far_pkg::ST_DIVN_WAIT: if (div_stat.done) state_d = far_pkg::ST_DIVD_GO;
			far_pkg::ST_DIVD_GO:   state_d = far_pkg::ST_DIVD_WAIT;
			far_pkg::ST_DIVD_WAIT: if (div_stat.done) state_d = far_pkg::ST_FIN;
			far_pkg::ST_FIN:       if (out_free) state_d = far_pkg::ST_IDLE;
			default:               state_d = far_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_ready     = 1'b0;
		mul_a        = mna_q;
		mul_b        = mdb_q;
		div_start    = 1'b0;
		div_dividend = mag_q;
		unique case (state_q)
			far_pkg::ST_IDLE:    in_ready = 1'b1;
			far_pkg::ST_MUL1: begin
				mul_a = mnb_q;
				mul_b = mda_q;
			end
			far_pkg::ST_MUL2: begin
				mul_a = mda_q;
				mul_b = mdb_q;
			end
			far_pkg::ST_DIVN_GO: div_start = 1'b1;
			far_pkg::ST_DIVD_GO: begin
				div_start    = 1'b1;
				div_dividend = den_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= far_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == far_pkg::ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			far_pkg::ST_IDLE: begin
				if (accept) begin
					mna_q <= far_pkg::mag32(num_a);
					mda_q <= far_pkg::mag32(den_a);
					mnb_q <= far_pkg::mag32(num_b);
					mdb_q <= far_pkg::mag32(den_b);
					sa_q  <= num_a[far_pkg::InW-1] != den_a[far_pkg::InW-1];
					sb_q  <= num_b[far_pkg::InW-1] != den_b[far_pkg::InW-1];
					bad_q <= in_bad;
					neg_q <= 1'b0;
					mag_q <= '0;
					den_q <= far_pkg::WideW'(1);
				end
			end
			far_pkg::ST_MUL1: p1_q  <= prod;
			far_pkg::ST_MUL2: p2_q  <= prod;
			far_pkg::ST_MUL3: den_q <= prod;
			far_pkg::ST_SUM: begin
				neg_q <= sum_neg;
				mag_q <= sum_mag;
				a_q   <= sum_mag;
				b_q   <= den_q;
				k_q   <= '0;
				if (sum_mag == '0) begin
					neg_q <= 1'b0;
					den_q <= far_pkg::WideW'(1);
				end
			end
			far_pkg::ST_TZ: begin
				// strip common factors of two
				if (!a_q[0] && !b_q[0]) begin
					a_q <= a_q >> 1;
					b_q <= b_q >> 1;
					k_q <= k_q + 6'd1;
				end
			end
			far_pkg::ST_GCD: begin
				if (a_q == '0) begin
					g_q <= b_q << k_q;
				end else if (!a_q[0]) begin
					a_q <= a_q >> 1;
				end else if (!b_q[0]) begin
					b_q <= b_q >> 1;
				end else if (a_ge_b) begin
					a_q <= a_q - b_q;
				end else begin
					b_q <= b_q - a_q;
				end
			end
			far_pkg::ST_DIVN_WAIT: if (div_stat.done) mag_q <= quotient;
			far_pkg::ST_DIVD_WAIT: if (div_stat.done) den_q <= quotient;
			far_pkg::ST_FIN: begin
				if (out_free) begin
					sum_num_q   <= neg_q ? (~mag_q + far_pkg::WideW'(1)) : mag_q;
					sum_den_q   <= den_q[far_pkg::DenW-1:0];
					bad_input_q <= bad_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign sum_num   = sum_num_q;
	assign sum_den   = sum_den_q;
	assign bad_input = bad_input_q;

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_input |-> sum_num == '0 && sum_den == far_pkg::DenW'(1))
		else $error("bad input result is not 0/1");

	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> sum_den != '0)
		else $error("zero denominator delivered");

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == far_pkg::ST_IDLE |-> !div_stat.busy)
		else $error("divider busy while sequencer idle");

endmodule

`default_nettype wire

### bench/tb.sv
`timescale 1ns / 1ps
`default_nettype none

module tb;

	typedef struct packed {
		logic signed [63:0] num;
		logic [61:0]        den;
		logic               bad;
	} frac_sum_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic signed [far_pkg::InW-1:0] num_a, den_a, num_b, den_b;
	logic out_valid;
	logic out_ready;
	logic signed [far_pkg::WideW-1:0] sum_num;
	logic [far_pkg::DenW-1:0] sum_den;
	logic bad_input;

	frac_sum_t sums_due[$];
	int unsigned mismatches;
	bit hold_rx;
	bit no_idle;

	fraction_add_reduce_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.num_a(num_a), .den_a(den_a), .num_b(num_b), .den_b(den_b),
		.out_valid(out_valid), .out_ready(out_ready),
		.sum_num(sum_num), .sum_den(sum_den), .bad_input(bad_input)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	initial begin
		#500ms;
		$display("status: fail");
		$finish;
	end

	function automatic logic [63:0] abs32(logic [31:0] v);
		return v[31] ? 64'(33'h1_0000_0000 - {1'b0, v}) : 64'(v);
	endfunction

	function automatic frac_sum_t reduced_sum(logic [31:0] na, logic [31:0] da,
			logic [31:0] nb, logic [31:0] db);
		frac_sum_t r;
		logic [63:0] mna, mda, mnb, mdb, p1, p2, den, mag, g, x, y, t;
		logic sa, sb, neg;
		mna = abs32(na);
		mda = abs32(da);
		mnb = abs32(nb);
		mdb = abs32(db);
		r.num = '0;
		r.den = 62'd1;
		r.bad = 1'b0;
		if (mda == 0 || mdb == 0) begin
			r.bad = 1'b1;
			return r;
		end
		// negative denominator flips the fraction's sign
		sa = na[31] ^ da[31];
		sb = nb[31] ^ db[31];
		p1 = mna * mdb;
		p2 = mnb * mda;
		den = mda * mdb;
		if (sa == sb) begin
			mag = p1 + p2;
			neg = sa;
		end else if (p1 >= p2) begin
			mag = p1 - p2;
			neg = sa;
		end else begin
			mag = p2 - p1;
			neg = sb;
		end
		if (mag == 0)
			return r;
		x = mag;
		y = den;
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		g = x;
		mag = mag / g;
		den = den / g;
		r.num = neg ? -mag : mag;
		r.den = den[61:0];
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %0h want %0h", what, got, want);
		mismatches++;
	endtask

	// valid drops only when a real gap follows, so the next item can go out at once
	task automatic short_gap(int unsigned longest);
		int unsigned n;
		if (no_idle)
			return;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, longest) : $urandom_range(0, 2);
		if (n != 0)
			in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic send_pair(logic [31:0] na, logic [31:0] da, logic [31:0] nb,
			logic [31:0] db);
		in_valid <= 1'b1;
		num_a <= na;
		den_a <= da;
		num_b <= nb;
		den_b <= db;
		do
			@(posedge clk);
		while (!in_ready);
		sums_due.push_back(reduced_sum(na, da, nb, db));
		short_gap(40);
	endtask

	// receiver side: random stalls, plus a long hold when asked, and no stalls in back-to-back mode
	always @(posedge clk) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else if (hold_rx)
			out_ready <= 1'b0;
		else if (no_idle)
			out_ready <= 1'b1;
		else
			out_ready <= ($urandom_range(0, 9) == 0) ? 1'b0 : 1'b1;
	end

	always @(posedge clk) begin
		frac_sum_t want;
		if (arst_n && out_valid && out_ready) begin
			if (sums_due.size() == 0) begin
				report_mismatch("unexpected item", sum_num, 64'(sum_den));
			end else begin
				want = sums_due.pop_front();
				if (sum_num !== want.num)
					report_mismatch("sum_num", sum_num, want.num);
				if (sum_den !== want.den)
					report_mismatch("sum_den", 64'(sum_den), 64'(want.den));
				if (bad_input !== want.bad)
					report_mismatch("bad_input", 64'(bad_input), 64'(want.bad));
			end
		end
	end

	function automatic logic [31:0] rand_field();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 20);
			1: return -$urandom_range(1, 20);
			2: return 32'h8000_0000 + $urandom_range(0, 3);
			3: return 32'h7fff_ffff - $urandom_range(0, 3);
			4: return $urandom_range(0, 1000) * ($urandom_range(0, 1) ? 1 : -1);
			default: return $urandom;
		endcase
	endfunction

	task automatic test_directed();
		send_pair(1, 2, 1, 3);
		send_pair(1, 2, -1, 2);
		send_pair(1, -2, 1, 2);
		send_pair(-3, -4, 1, 4);
		send_pair(5, 0, 1, 3);
		send_pair(1, 3, 7, 0);
		send_pair(0, 0, 0, 0);
		send_pair(0, 5, 0, -7);
		send_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_pair(32'h8000_0000, 1, 32'h8000_0000, 1);
		send_pair(32'h7fff_ffff, 1, 32'h7fff_ffff, 1);
		send_pair(32'h7fff_ffff, 32'h7fff_fffe, 32'h7fff_fffe, 32'h7fff_ffff);
		send_pair(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
		send_pair(-1, 32'h8000_0000, 1, 32'h7fff_ffff);
		send_pair(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
		send_pair(6, 4, 10, 15);
		send_pair(32'h8000_0001, 32'h7fff_ffff, 2, 1);
		in_valid <= 1'b0;
	endtask

	task automatic test_random(int unsigned count);
		repeat (count)
			send_pair(rand_field(), rand_field(), rand_field(), rand_field());
		in_valid <= 1'b0;
	endtask

	// hold off the output so the core fills and stalls its input
	task automatic test_backpressure();
		hold_rx = 1'b1;
		fork
			test_random(4);
			begin
				repeat (3000) @(posedge clk);
				hold_rx = 1'b0;
			end
		join
	endtask

	task automatic test_back_to_back();
		no_idle = 1'b1;
		test_random(30);
		no_idle = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		num_a = '0;
		den_a = '0;
		num_b = '0;
		den_b = '0;
		hold_rx = 1'b0;
		no_idle = 1'b0;
		mismatches = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_back_to_back();
		test_random(400);
		while (sums_due.size() != 0)
			@(posedge clk);
		repeat (500) @(posedge clk);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

`default_nettype wire
